@@ hdl/xte_pkg.sv @@
// Shared types, constants and helpers for the XML text escaper.
// No dependencies; every module in hdl/ imports this package.
package xte_pkg;

   localparam int unsigned ESC_MAX_LEN = 6;                     // longest escape: &#xHH;
   localparam int unsigned IDX_W       = $clog2(ESC_MAX_LEN);
   localparam int unsigned TEXT_W      = 8 * ESC_MAX_LEN;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Escape text, left-aligned: first output character in the top byte.
   localparam logic [TEXT_W-1:0] ENT_LT   = {"&lt;", 16'h0000};
   localparam logic [TEXT_W-1:0] ENT_GT   = {"&gt;", 16'h0000};
   localparam logic [TEXT_W-1:0] ENT_AMP  = {"&amp;", 8'h00};
   localparam logic [TEXT_W-1:0] ENT_APOS = "&apos;";
   localparam logic [TEXT_W-1:0] ENT_QUOT = "&quot;";
   localparam logic [23:0]       NUM_HEAD = "&#x";
   localparam logic [7:0]        NUM_TAIL = ";";

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LT  = "<";
   localparam logic [7:0] CH_GT  = ">";
   localparam logic [7:0] CH_AMP = "&";
   localparam logic [7:0] CH_APO = "'";
   localparam logic [7:0] CH_QUO = "\"";
   localparam logic [7:0] CH_SPC = 8'h20;
   localparam logic [7:0] CH_NUL = 8'h00;

   // One classified input byte, as queued between front and back.
   typedef struct packed {
      logic [TEXT_W-1:0] text;      // characters of the run, first in top byte
      logic [IDX_W-1:0]  last_idx;  // run length minus one
      logic              fin;       // string_end of the input byte
      logic              null_err;  // input byte was zero
   } esc_entry_type;

   // Upper-case hex digit for a nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = {4'h3, nib};
      end else begin
         ch = 8'h37 + {4'h0, nib};
      end
      return ch;
   endfunction

   // Character at position idx of a left-aligned run.
   function automatic logic [7:0] text_char(input logic [TEXT_W-1:0] text,
                                            input logic [IDX_W-1:0]  idx);
      logic [TEXT_W-1:0] shifted;
      shifted = text << {idx, 3'b000};
      return shifted[TEXT_W-1 -: 8];
   endfunction

endpackage

@@ hdl/xte_if.sv @@
// Valid/ready channel interfaces for the XML text escaper.
// Depends on nothing; request carries one byte, response one character.
interface xte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_end;

   modport source (output valid, in_byte, string_end, input ready);
   modport sink   (input valid, in_byte, string_end, output ready);
endinterface

interface xte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;
   logic       string_last;
   logic       null_error;

   modport source (output valid, out_char, run_last, string_last, null_error, input ready);
   modport sink   (input valid, out_char, run_last, string_last, null_error, output ready);
endinterface

@@ hdl/xml_text_escaper.sv @@
// Top level of the XML text escaper: classifier, run queue and expander.
// Depends on xte_pkg, xte_if, xte_classify, xte_queue and xte_expand.
//
//   channel    dir  payload                                      role
//   req_chan   in   in_byte[7:0], string_end                     raw string bytes
//   rsp_chan   out  out_char[7:0], run_last, string_last,        escaped text, one
//                   null_error                                   character each
//
// One response character per cycle while rsp_chan.ready holds: a plain byte
// gives 1 character, an entity 4 to 6, set by the single expander output port.
// A request passes through the queue memory, then the expander output register.
// Reset clears the queue pointers and count, run index and output valid.
// A response stall holds the output register; the 4-entry run queue keeps
// taking requests until full, then deasserts req_chan.ready.
module xml_text_escaper
   import xte_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   xte_req_if.sink   req_chan,
   xte_rsp_if.source rsp_chan
);

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   esc_entry_type q_entry;
   esc_entry_type q_head;

   xte_classify u_classify (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   xte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   xte_expand u_expand (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ hdl/xte_classify.sv @@
// Front end: accepts request transactions and classifies each byte into an
// escape run (text plus length). Depends on xte_pkg and xte_if.
module xte_classify
   import xte_pkg::*;
(
   xte_req_if.sink               req_chan,
   input  logic                  q_full,
   output logic                  q_push,
   output esc_entry_type         q_entry
);

   logic [7:0] b;
   logic       is_ctrl;

   assign b       = req_chan.in_byte;
   assign is_ctrl = (b < CH_SPC) && (b != CH_TAB) && (b != CH_LF) && (b != CH_CR)
                    && (b != CH_NUL);

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   always_comb begin
      q_entry.fin      = req_chan.string_end;
      q_entry.null_err = (b == CH_NUL);
      q_entry.text     = {b, {(TEXT_W-8){1'b0}}};
      q_entry.last_idx = '0;
      case (b)
         CH_LT: begin
            q_entry.text     = ENT_LT;
            q_entry.last_idx = IDX_W'(3);
         end
         CH_GT: begin
            q_entry.text     = ENT_GT;
            q_entry.last_idx = IDX_W'(3);
         end
         CH_AMP: begin
            q_entry.text     = ENT_AMP;
            q_entry.last_idx = IDX_W'(4);
         end
         CH_APO: begin
            q_entry.text     = ENT_APOS;
            q_entry.last_idx = IDX_W'(5);
         end
         CH_QUO: begin
            q_entry.text     = ENT_QUOT;
            q_entry.last_idx = IDX_W'(5);
         end
         default: begin
            if (is_ctrl) begin
               q_entry.text     = {NUM_HEAD, hex_digit(b[7:4]), hex_digit(b[3:0]), NUM_TAIL};
               q_entry.last_idx = IDX_W'(ESC_MAX_LEN - 1);
            end
         end
      endcase
   end

endmodule

@@ hdl/xte_queue.sv @@
// Small FIFO of classified runs between the front and back ends.
// Depends on xte_pkg.
module xte_queue
   import xte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  esc_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output esc_entry_type head
);

   esc_entry_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_pop;

   assign full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign head   = mem_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/xte_expand.sv @@
// Back end: walks the head run one character per cycle, unless the response
// stalls, into a registered response stage. Depends on xte_pkg and xte_if.
module xte_expand
   import xte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  esc_entry_type q_head,
   output logic          q_pop,
   xte_rsp_if.source     rsp_chan
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       char_ff, char_in;
   logic             run_last_ff, run_last_in;
   logic             str_last_ff, str_last_in;
   logic             null_ff, null_in;
   logic             load;
   logic             at_last;

   // Output stage takes a new character when empty or being drained.
   assign load    = !q_empty && (!valid_ff || rsp_chan.ready);
   assign at_last = (idx_ff == q_head.last_idx);
   assign q_pop   = load && at_last;

   always_comb begin
      idx_in      = idx_ff;
      valid_in    = valid_ff && !rsp_chan.ready;
      char_in     = char_ff;
      run_last_in = run_last_ff;
      str_last_in = str_last_ff;
      null_in     = null_ff;
      if (load) begin
         valid_in    = 1'b1;
         char_in     = text_char(q_head.text, idx_ff);
         run_last_in = at_last;
         str_last_in = at_last && q_head.fin;
         null_in     = q_head.null_err;
         idx_in      = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      run_last_ff <= run_last_in;
      str_last_ff <= str_last_in;
      null_ff     <= null_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_char    = char_ff;
   assign rsp_chan.run_last    = run_last_ff;
   assign rsp_chan.string_last = str_last_ff;
   assign rsp_chan.null_error  = null_ff;

endmodule
